FILE: hdl/etrc_pkg.sv
// ----------------------------------------------------------------------------
// etrc_pkg: shared types and constants of the expiring tag replay cache
// Slot layout, probe summary, status and command codes, state encoding,
// and the small helper functions used by the top module.
// ----------------------------------------------------------------------------
package etrc_pkg;

    localparam int SLOT_COUNT = 16;
    localparam int TAG_BYTES  = 32;
    localparam int TAG_WORDS  = 4;
    localparam int TIME_W     = 64;
    localparam int IDX_W      = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
    localparam int CNT_W      = $clog2(SLOT_COUNT + 1);
    localparam int LIVE_W     = 5;
    localparam int LIVE_MAX   = 31;

    typedef logic [TIME_W-1:0] stamp_t;

    localparam stamp_t DEF_LIFETIME = 64'd300;
    localparam stamp_t DEF_SKEW     = 64'd60;

    typedef enum logic [1:0] {
        STATUS_OK      = 2'd0,
        STATUS_REPLAY  = 2'd1,
        STATUS_UNAVAIL = 2'd2
    } status_t;

    typedef enum logic {
        CMD_DELIVER = 1'b0,
        CMD_QUERY   = 1'b1
    } cmd_t;

    typedef enum logic {
        CFG_LIFETIME = 1'b0,
        CFG_SKEW     = 1'b1
    } cfg_idx_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_COMMIT,
        ST_RESULT
    } state_t;

    typedef struct packed {
        logic                               used;
        stamp_t                             expiry;
        logic [TAG_WORDS-1:0][TIME_W-1:0]   tag;
    } slot_t;

    typedef struct packed {
        logic             hit;
        logic             free_ok;
        logic [IDX_W-1:0] free_idx;
        logic             exp_ok;
        logic [IDX_W-1:0] exp_idx;
        logic [CNT_W-1:0] live;
    } probe_t;

    // Byte 0 of a word sits in its top byte; bytes past the tag length are cleared.
    function automatic logic [TIME_W-1:0] word_mask(input int w);
        logic [TIME_W-1:0] mask;
        mask = '0;
        for (int b = 0; b < 8; b++)
        begin
            mask[TIME_W-1-8*b -: 8] = ((8 * w + b) < TAG_BYTES) ? 8'hFF : 8'h00;
        end
        return mask;
    endfunction

    function automatic stamp_t sat_add(input stamp_t a, input stamp_t b);
        logic [TIME_W:0] sum;
        sum = {1'b0, a} + {1'b0, b};
        return sum[TIME_W] ? '1 : sum[TIME_W-1:0];
    endfunction

endpackage

FILE: hdl/etrc_cell.sv
// ----------------------------------------------------------------------------
// etrc_cell: one slot of the circulating slot ring
// Holds used flag, expiry and tag; shifts to its neighbor or takes a write.
// ----------------------------------------------------------------------------
module etrc_cell
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            shift_en,
    input  etrc_pkg::slot_t shift_in,
    input  logic            wr_en,
    input  etrc_pkg::slot_t wr_data,
    output etrc_pkg::slot_t slot
);

    logic                                                   used_reg;
    logic                                                   used_next;
    etrc_pkg::stamp_t                                       expiry_reg;
    etrc_pkg::stamp_t                                       expiry_next;
    logic [etrc_pkg::TAG_WORDS-1:0][etrc_pkg::TIME_W-1:0]   tag_reg;
    logic [etrc_pkg::TAG_WORDS-1:0][etrc_pkg::TIME_W-1:0]   tag_next;

    always_comb
    begin
        used_next   = used_reg;
        expiry_next = expiry_reg;
        tag_next    = tag_reg;
        if (wr_en)
        begin
            used_next   = wr_data.used;
            expiry_next = wr_data.expiry;
            tag_next    = wr_data.tag;
        end
        else if (shift_en)
        begin
            used_next   = shift_in.used;
            expiry_next = shift_in.expiry;
            tag_next    = shift_in.tag;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            used_reg <= 1'b0;
        end
        else
        begin
            used_reg <= used_next;
        end
    end

    always_ff @(posedge clk)
    begin
        expiry_reg <= expiry_next;
        tag_reg    <= tag_next;
    end

    assign slot.used   = used_reg;
    assign slot.expiry = expiry_reg;
    assign slot.tag    = tag_reg;

endmodule

FILE: hdl/etrc_probe.sv
// ----------------------------------------------------------------------------
// etrc_probe: examines the slot at the head of the ring, one per cycle while enabled
// Accumulates replay hit, first unused slot, first expired slot, live count.
// ----------------------------------------------------------------------------
module etrc_probe
(
    input  logic                                                 clk,
    input  logic                                                 rst_n,
    input  logic                                                 clear,
    input  logic                                                 enable,
    input  logic [etrc_pkg::IDX_W-1:0]                           head_idx,
    input  etrc_pkg::slot_t                                      head,
    input  logic [etrc_pkg::TAG_WORDS-1:0][etrc_pkg::TIME_W-1:0] req_tag,
    input  etrc_pkg::stamp_t                                     now,
    output etrc_pkg::probe_t                                     summary
);

    etrc_pkg::probe_t probe_reg;
    etrc_pkg::probe_t probe_next;
    logic             live;
    logic             expired;
    logic             tag_eq;

    assign live    = head.used && (head.expiry > now);
    assign expired = head.used && (head.expiry <= now);
    assign tag_eq  = (head.tag == req_tag);

    always_comb
    begin
        probe_next = probe_reg;
        if (clear)
        begin
            probe_next = '0;
        end
        else if (enable)
        begin
            if (live && tag_eq)
            begin
                probe_next.hit = 1'b1;
            end
            if (!probe_reg.free_ok && !head.used)
            begin
                probe_next.free_ok  = 1'b1;
                probe_next.free_idx = head_idx;
            end
            if (!probe_reg.exp_ok && expired)
            begin
                probe_next.exp_ok  = 1'b1;
                probe_next.exp_idx = head_idx;
            end
            if (live)
            begin
                probe_next.live = probe_reg.live + 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            probe_reg <= '0;
        end
        else
        begin
            probe_reg <= probe_next;
        end
    end

    assign summary = probe_reg;

endmodule

FILE: hdl/expiring_tag_replay_cache.sv
// ----------------------------------------------------------------------------
// expiring_tag_replay_cache: replay detection over a ring of expiring tag slots
// A request is taken only in idle; the controller then rotates the ring once,
// commits, loads the result and returns to idle before it takes the next one.
// The output register lets the next request start while a result waits.
// Reset clears all used flags, the controller and the output; registers return
// to 300 (lifetime) and 60 (skew). Tag and expiry storage are not reset.
// ----------------------------------------------------------------------------
module expiring_tag_replay_cache
(
    input  logic         clk,
    input  logic         rst_n,
    // Request stream.
    input  logic         s_tvalid,
    output logic         s_tready,
    // tdata: tag_word0[63:0], tag_word1, tag_word2, tag_word3, claim_issue_time,
    //        current_time[383:320]
    input  logic [383:0] s_tdata,
    // tuser: command[0]
    input  logic [0:0]   s_tuser,
    // Result stream.
    output logic         m_tvalid,
    input  logic         m_tready,
    // tdata: status[1:0], live_count[6:2], zero pad[7]
    output logic [7:0]   m_tdata,
    // Configuration write port.
    input  logic         cfg_we,
    input  logic [0:0]   cfg_index,
    input  logic [63:0]  cfg_data
);

    localparam int TW = etrc_pkg::TIME_W;
    localparam int NS = etrc_pkg::SLOT_COUNT;

    // Controller state.
    etrc_pkg::state_t state_reg;
    etrc_pkg::state_t state_next;
    logic [etrc_pkg::IDX_W-1:0] step_reg;
    logic [etrc_pkg::IDX_W-1:0] step_next;
    logic scan_last;

    // Controller outputs.
    logic accept;
    logic scan_en;
    logic commit;
    logic result_load;

    // Configuration registers.
    etrc_pkg::stamp_t life_reg;
    etrc_pkg::stamp_t skew_reg;
    etrc_pkg::stamp_t life_eff;
    etrc_pkg::stamp_t skew_eff;

    // Request held for the duration of one ring rotation.
    etrc_pkg::cmd_t   cmd_reg;
    etrc_pkg::stamp_t now_reg;
    etrc_pkg::stamp_t ddl_reg;
    etrc_pkg::stamp_t ddl_next;
    logic [etrc_pkg::TAG_WORDS-1:0][TW-1:0] tag_reg;

    // Ring and probe.
    etrc_pkg::slot_t  slot_q [NS];
    etrc_pkg::slot_t  wr_slot;
    etrc_pkg::probe_t probe;
    logic             commit_we;
    logic [etrc_pkg::IDX_W-1:0] target_idx;

    // Result path.
    etrc_pkg::status_t          status_next;
    logic [etrc_pkg::LIVE_W-1:0] live_next;
    etrc_pkg::status_t          pend_status_reg;
    logic [etrc_pkg::LIVE_W-1:0] pend_live_reg;
    logic                       out_valid_reg;
    logic [7:0]                 out_data_reg;

    // ------------------------------------------------------------------
    // Configuration. A zero register falls back to its reset value.
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            life_reg <= etrc_pkg::DEF_LIFETIME;
            skew_reg <= etrc_pkg::DEF_SKEW;
        end
        else if (cfg_we)
        begin
            unique case (etrc_pkg::cfg_idx_t'(cfg_index))
                etrc_pkg::CFG_LIFETIME: life_reg <= cfg_data;
                etrc_pkg::CFG_SKEW:     skew_reg <= cfg_data;
                default:                life_reg <= life_reg;
            endcase
        end
    end

    assign life_eff = (life_reg == '0) ? etrc_pkg::DEF_LIFETIME : life_reg;
    assign skew_eff = (skew_reg == '0) ? etrc_pkg::DEF_SKEW : skew_reg;

    // ------------------------------------------------------------------
    // Controller: next state.
    // ------------------------------------------------------------------
    assign scan_last = (step_reg == etrc_pkg::IDX_W'(NS - 1));

    always_comb
    begin
        state_next = state_reg;
        step_next  = step_reg;
        unique case (state_reg)
            etrc_pkg::ST_IDLE:
            begin
                step_next = '0;
                if (s_tvalid)
                begin
                    state_next = etrc_pkg::ST_SCAN;
                end
            end
            etrc_pkg::ST_SCAN:
            begin
                step_next = step_reg + 1'b1;
                if (scan_last)
                begin
                    state_next = etrc_pkg::ST_COMMIT;
                    step_next  = '0;
                end
            end
            etrc_pkg::ST_COMMIT:
            begin
                state_next = etrc_pkg::ST_RESULT;
            end
            etrc_pkg::ST_RESULT:
            begin
                if (!out_valid_reg || m_tready)
                begin
                    state_next = etrc_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = etrc_pkg::ST_IDLE;
            end
        endcase
    end

    // ------------------------------------------------------------------
    // Controller: outputs.
    // ------------------------------------------------------------------
    always_comb
    begin
        s_tready    = 1'b0;
        scan_en     = 1'b0;
        commit      = 1'b0;
        result_load = 1'b0;
        unique case (state_reg)
            etrc_pkg::ST_IDLE:   s_tready    = 1'b1;
            etrc_pkg::ST_SCAN:   scan_en     = 1'b1;
            etrc_pkg::ST_COMMIT: commit      = 1'b1;
            etrc_pkg::ST_RESULT: result_load = !out_valid_reg || m_tready;
            default:             s_tready    = 1'b0;
        endcase
    end

    assign accept = s_tvalid && s_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= etrc_pkg::ST_IDLE;
            step_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            step_reg  <= step_next;
        end
    end

    // ------------------------------------------------------------------
    // Request capture. The deadline is built in two saturating adds: the
    // lifetime at acceptance, the skew in the first scan step.
    // ------------------------------------------------------------------
    always_comb
    begin
        ddl_next = ddl_reg;
        if (accept)
        begin
            ddl_next = etrc_pkg::sat_add(s_tdata[4*TW +: TW], life_eff);
        end
        else if (scan_en && (step_reg == '0))
        begin
            ddl_next = etrc_pkg::sat_add(ddl_reg, skew_eff);
        end
    end

    always_ff @(posedge clk)
    begin
        ddl_reg <= ddl_next;
        if (accept)
        begin
            cmd_reg <= etrc_pkg::cmd_t'(s_tuser[0]);
            now_reg <= s_tdata[5*TW +: TW];
            for (int w = 0; w < etrc_pkg::TAG_WORDS; w++)
            begin
                tag_reg[w] <= s_tdata[w*TW +: TW] & etrc_pkg::word_mask(w);
            end
        end
    end

    // ------------------------------------------------------------------
    // Slot ring. Each cell takes its upper neighbor during a scan, so after
    // one full rotation every slot is back in place and cell 0 has shown
    // each slot to the probe in index order.
    // ------------------------------------------------------------------
    assign wr_slot.used   = 1'b1;
    assign wr_slot.expiry = ddl_reg;
    assign wr_slot.tag    = tag_reg;

    for (genvar i = 0; i < NS; i++)
    begin : g_ring
        localparam int NEXT = (i + 1) % NS;
        etrc_cell u_cell
        (
            .clk      (clk),
            .rst_n    (rst_n),
            .shift_en (scan_en),
            .shift_in (slot_q[NEXT]),
            .wr_en    (commit_we && (target_idx == etrc_pkg::IDX_W'(i))),
            .wr_data  (wr_slot),
            .slot     (slot_q[i])
        );
    end

    etrc_probe u_probe
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .clear    (accept),
        .enable   (scan_en),
        .head_idx (step_reg),
        .head     (slot_q[0]),
        .req_tag  (tag_reg),
        .now      (now_reg),
        .summary  (probe)
    );

    // ------------------------------------------------------------------
    // Commit: decide the status and store the tag. An unused slot wins
    // over an expired one; replay and a missing clock store nothing.
    // ------------------------------------------------------------------
    assign target_idx = probe.free_ok ? probe.free_idx : probe.exp_idx;
    assign commit_we  = commit && (cmd_reg == etrc_pkg::CMD_DELIVER) && (now_reg != '0)
                        && !probe.hit && (probe.free_ok || probe.exp_ok);

    always_comb
    begin
        status_next = etrc_pkg::STATUS_OK;
        live_next   = '0;
        if (cmd_reg == etrc_pkg::CMD_QUERY)
        begin
            live_next = (32'(probe.live) > 32'(etrc_pkg::LIVE_MAX))
                        ? etrc_pkg::LIVE_W'(etrc_pkg::LIVE_MAX)
                        : etrc_pkg::LIVE_W'(probe.live);
        end
        else if (now_reg == '0)
        begin
            status_next = etrc_pkg::STATUS_UNAVAIL;
        end
        else if (probe.hit)
        begin
            status_next = etrc_pkg::STATUS_REPLAY;
        end
        else if (!(probe.free_ok || probe.exp_ok))
        begin
            status_next = etrc_pkg::STATUS_UNAVAIL;
        end
    end

    always_ff @(posedge clk)
    begin
        if (commit)
        begin
            pend_status_reg <= status_next;
            pend_live_reg   <= live_next;
        end
    end

    // ------------------------------------------------------------------
    // Output register.
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (result_load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (result_load)
        begin
            out_data_reg <= {1'b0, pend_live_reg, pend_status_reg};
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

`ifndef SYNTHESIS
    // A stored tag never overwrites a slot that is still live.
    a_no_live_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        commit_we |-> !(slot_q[target_idx].used && (slot_q[target_idx].expiry > now_reg)))
        else $error("commit overwrote a live slot");

    // A replay or a missing clock never stores anything.
    a_no_store_on_reject: assert property (@(posedge clk) disable iff (!rst_n)
        commit_we |-> (!probe.hit && (now_reg != '0)))
        else $error("tag stored on a rejected delivery");

    // The last scan step is always followed by the commit.
    a_scan_to_commit: assert property (@(posedge clk) disable iff (!rst_n)
        (scan_en && scan_last) |=> (state_reg == etrc_pkg::ST_COMMIT))
        else $error("scan did not end in commit");

    // The live count can never pass the number of slots.
    a_live_bound: assert property (@(posedge clk) disable iff (!rst_n)
        32'(probe.live) <= NS)
        else $error("live count exceeds slot count");
`endif

endmodule

FILE: bench/expiring_tag_replay_cache_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// expiring_tag_replay_cache_tb: self-checking bench for the replay cache
// Requests go in on the slave stream, and the result of each one comes back
// on the master stream. A shadow copy of the slot table predicts the status
// and live count of every accepted request. Each result is checked in order.
// Directed tests cover the missing clock, replay, expiry at the exact
// deadline, saturation, zero registers and a full table. Random traffic phases
// follow with tags drawn from small pools, so replays and expirations occur
// often. Both streams see random gaps and back pressure.
// ----------------------------------------------------------------------------
module expiring_tag_replay_cache_tb;

    import etrc_pkg::*;

    typedef logic [TAG_WORDS-1:0][63:0] tag_t;

    typedef struct packed {
        status_t           status;
        logic [LIVE_W-1:0] live_count;
    } verdict_t;

    localparam int POOL_MAX = 32;

    logic         clk = 1'b0;
    logic         rst_n = 1'b0;
    logic         s_tvalid = 1'b0;
    logic         s_tready;
    logic [383:0] s_tdata = '0;
    logic [0:0]   s_tuser = '0;
    logic         m_tvalid;
    logic         m_tready = 1'b0;
    logic [7:0]   m_tdata;
    logic         cfg_we = 1'b0;
    logic [0:0]   cfg_index = '0;
    logic [63:0]  cfg_data = '0;

    // Shadow copy of the slot table and of the two retention registers.
    tag_t   shadow_tag    [SLOT_COUNT];
    stamp_t shadow_expiry [SLOT_COUNT];
    logic   shadow_used   [SLOT_COUNT];
    stamp_t shadow_lifetime;
    stamp_t shadow_skew;

    // Predicted results of accepted requests, oldest first.
    verdict_t verdict_q[$];

    tag_t   tag_pool [POOL_MAX];
    stamp_t clock_sec;
    int     error_count = 0;
    bit     req_held = 1'b0;
    bit     tx_steady = 1'b0;
    bit     rx_steady = 1'b0;

    expiring_tag_replay_cache u_top
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    initial
    begin
        #10_000_000;
        $display("** expiring_tag_replay_cache: FAILED **");
        $finish;
    end

    function automatic logic [63:0] rand64();
        return {$urandom, $urandom};
    endfunction

    function automatic stamp_t sat_sum(input stamp_t a, input stamp_t b);
        // a + b overflows exactly when a exceeds the headroom ~b.
        return (a > ~b) ? '1 : a + b;
    endfunction

    // Applies one request to the shadow table and returns its result.
    function automatic verdict_t cache_verdict(input cmd_t cmd, input tag_t tag_in,
                                               input stamp_t issue, input stamp_t now);
        verdict_t    v;
        tag_t        tag;
        logic [63:0] mask;
        int          n;
        int          slot;
        v.status     = STATUS_OK;
        v.live_count = '0;
        if (cmd == CMD_QUERY)
        begin
            n = 0;
            for (int s = 0; s < SLOT_COUNT; s++)
                if (shadow_used[s] && shadow_expiry[s] > now)
                    n++;
            v.live_count = LIVE_W'((n > LIVE_MAX) ? LIVE_MAX : n);
            return v;
        end
        if (now == '0)
        begin
            v.status = STATUS_UNAVAIL;
            return v;
        end
        // Only the leading tag bytes take part; byte 0 is the top byte of word 0.
        for (int w = 0; w < TAG_WORDS; w++)
        begin
            n = TAG_BYTES - 8 * w;
            if (n >= 8)
                mask = '1;
            else if (n <= 0)
                mask = '0;
            else
                mask = ~((64'd1 << (64 - 8 * n)) - 64'd1);
            tag[w] = tag_in[w] & mask;
        end
        for (int s = 0; s < SLOT_COUNT; s++)
        begin
            if (shadow_used[s] && shadow_expiry[s] > now && shadow_tag[s] == tag)
            begin
                v.status = STATUS_REPLAY;
                return v;
            end
        end
        // First unused slot wins; only when all are used, the first expired one.
        slot = -1;
        for (int s = 0; s < SLOT_COUNT; s++)
            if (slot < 0 && !shadow_used[s])
                slot = s;
        for (int s = 0; s < SLOT_COUNT; s++)
            if (slot < 0 && shadow_expiry[s] <= now)
                slot = s;
        if (slot < 0)
        begin
            v.status = STATUS_UNAVAIL;
            return v;
        end
        shadow_tag[slot]    = tag;
        shadow_expiry[slot] = sat_sum(sat_sum(issue,
                                  (shadow_lifetime == '0) ? DEF_LIFETIME : shadow_lifetime),
                                  (shadow_skew == '0) ? DEF_SKEW : shadow_skew);
        shadow_used[slot]   = 1'b1;
        return v;
    endfunction

    task automatic report_error(input string msg);
        error_count++;
        if (error_count <= 50)
            $display("[%0t] MISMATCH: %s", $time, msg);
    endtask

    // Offers one request, waits for the handshake, records the prediction and
    // then idles for a random gap. With no gap, tvalid simply stays high.
    task automatic send_request(input cmd_t cmd, input tag_t tag,
                                input stamp_t issue, input stamp_t now);
        int r;
        int gap;
        s_tvalid <= 1'b1;
        s_tdata  <= {now, issue, tag};
        s_tuser  <= cmd;
        req_held = 1'b1;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        verdict_q.push_back(cache_verdict(cmd, tag, issue, now));
        r = $urandom_range(0, 99);
        if (tx_steady || r < 55)
            gap = 0;
        else if (r < 85)
            gap = $urandom_range(1, 3);
        else if (r < 97)
            gap = $urandom_range(4, 20);
        else
            gap = $urandom_range(21, 80);
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            req_held = 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    // Stops offering requests and waits until every predicted result is back.
    task automatic settle();
        if (req_held)
        begin
            s_tvalid <= 1'b0;
            req_held = 1'b0;
        end
        while (verdict_q.size() != 0)
            @(posedge clk);
        repeat (3) @(posedge clk);
    endtask

    // Writes the lifetime register, then the skew register; only called when idle.
    task automatic write_config(input stamp_t lifetime, input stamp_t skew);
        cfg_we    <= 1'b1;
        cfg_index <= CFG_LIFETIME;
        cfg_data  <= lifetime;
        @(posedge clk);
        shadow_lifetime = lifetime;
        cfg_index <= CFG_SKEW;
        cfg_data  <= skew;
        @(posedge clk);
        shadow_skew = skew;
        cfg_we <= 1'b0;
    endtask

    task automatic new_tag_pool(input int count);
        for (int p = 0; p < count; p++)
            tag_pool[p] = {rand64(), rand64(), rand64(), rand64()};
    endtask

    // Missing clock, replay inside the window and expiry right at the deadline.
    task automatic test_clock_and_expiry();
        tag_t tag_a;
        tag_t tag_near;
        tag_a    = {64'h0123_4567_89AB_CDEF, 64'hFEDC_BA98_7654_3210,
                    64'h0F1E_2D3C_4B5A_6978, 64'h8796_A5B4_C3D2_E1F0};
        tag_near = tag_a;
        tag_near[0][0] = ~tag_near[0][0];
        send_request(CMD_QUERY,   tag_a,    64'd0,    64'd0);
        send_request(CMD_DELIVER, tag_a,    64'd1000, 64'd0);
        send_request(CMD_DELIVER, tag_a,    64'd1000, 64'd1000);
        send_request(CMD_DELIVER, tag_a,    64'd1000, 64'd1359);
        send_request(CMD_DELIVER, tag_near, 64'd1000, 64'd1359);
        send_request(CMD_QUERY,   tag_a,    64'd0,    64'd1359);
        send_request(CMD_QUERY,   tag_a,    64'd0,    64'd1360);
        send_request(CMD_DELIVER, tag_a,    64'd1000, 64'd1360);
    endtask

    // Register extremes: saturating deadlines, then the shortest retention.
    task automatic test_register_extremes();
        tag_t tag_b;
        tag_b = {4{64'hA5A5_5A5A_C3C3_3C3C}};
        settle();
        write_config('1, '1);
        send_request(CMD_DELIVER, '1, '1,    64'd2000);
        send_request(CMD_DELIVER, '0, 64'd0, 64'd1);
        send_request(CMD_DELIVER, '1, 64'd0, 64'hFFFF_FFFF_FFFF_FFFE);
        send_request(CMD_DELIVER, '1, 64'd0, '1);
        send_request(CMD_QUERY,   '0, 64'd0, '1);
        send_request(CMD_QUERY,   '1, '1,    64'hFFFF_FFFF_FFFF_FFFE);
        settle();
        write_config(64'd1, 64'd1);
        send_request(CMD_DELIVER, tag_b, 64'd3000, 64'd3000);
        send_request(CMD_QUERY,   tag_b, 64'd0,    64'd3001);
        send_request(CMD_QUERY,   tag_b, 64'd0,    64'd3002);
        send_request(CMD_DELIVER, tag_b, 64'd3002, 64'd3002);
    endtask

    // Zero registers fall back to the defaults; then the table runs full.
    task automatic test_table_full();
        tag_t tag;
        settle();
        write_config('0, '0);
        for (int i = 0; i < 14; i++)
        begin
            tag = {4{64'h1000_0000_0000_0000 + 64'(i)}};
            send_request(CMD_DELIVER, tag, 64'd5000, 64'd5000);
        end
        send_request(CMD_QUERY, '0, 64'd0, 64'd5000);
        tag = {4{64'h1000_0000_0000_0003}};
        send_request(CMD_DELIVER, tag, 64'd5000, 64'd5359);
        send_request(CMD_DELIVER, '0,  64'd5360, 64'd5360);
    endtask

    // Random requests around a running clock. Tags come mostly from the pool,
    // some with one bit flipped, some fresh. top_pct sets how often the clock
    // reads its largest value, which expires even saturated slots.
    task automatic run_traffic(input int count, input int max_step, input int pool_size,
                               input int top_pct);
        tag_t   tag;
        stamp_t issue;
        stamp_t now;
        cmd_t   cmd;
        int     r;
        int     wi;
        int     bi;
        for (int i = 0; i < count; i++)
        begin
            clock_sec += $urandom_range(0, max_step);
            tag = tag_pool[$urandom_range(0, pool_size - 1)];
            r = $urandom_range(0, 99);
            if (r < 10)
            begin
                wi = $urandom_range(0, TAG_WORDS - 1);
                bi = $urandom_range(0, 63);
                tag[wi][bi] = ~tag[wi][bi];
            end
            else if (r < 20)
                tag = {rand64(), rand64(), rand64(), rand64()};
            cmd = ($urandom_range(0, 99) < 15) ? CMD_QUERY : CMD_DELIVER;
            now = clock_sec;
            r = $urandom_range(0, 99);
            if (r < 3)
                now = '0;
            else if (r < 5)
                now = rand64();
            else if (r < 5 + top_pct)
                now = '1;
            issue = clock_sec - $urandom_range(0, 4 * max_step);
            r = $urandom_range(0, 99);
            if (r < 10)
                issue = clock_sec + $urandom_range(0, max_step);
            else if (r < 20 && (cmd == CMD_QUERY || now == '0))
                issue = rand64();
            send_request(cmd, tag, issue, now);
            if ($urandom_range(0, 99) == 0)
                settle();
        end
    endtask

    task automatic test_random_phases();
        clock_sec = 64'd10000;

        // Two-second retention: expirations dominate, replays need a quick repeat.
        settle();
        write_config(64'd1, 64'd1);
        new_tag_pool(8);
        run_traffic(120, 2, 8, 0);

        // Default retention with a clock that fills the table.
        settle();
        write_config(64'd300, 64'd60);
        new_tag_pool(24);
        run_traffic(150, 40, 24, 0);

        // Mid-range settings, first with both streams running flat out.
        settle();
        write_config(64'($urandom_range(1, 500)), 64'($urandom_range(1, 100)));
        new_tag_pool(16);
        tx_steady = 1'b1;
        rx_steady = 1'b1;
        run_traffic(100, 30, 16, 0);
        tx_steady = 1'b0;
        rx_steady = 1'b0;
        run_traffic(100, 30, 16, 0);

        // Short retention, small pool, frequent replays and pauses.
        settle();
        write_config(64'd20, 64'd5);
        new_tag_pool(6);
        run_traffic(100, 3, 6, 0);
        settle();
        run_traffic(100, 3, 6, 0);

        // Largest registers last: every deadline saturates and slots only free
        // up when the clock reads its top value.
        settle();
        write_config('1, '1);
        new_tag_pool(20);
        run_traffic(60, 10, 20, 6);
    endtask

    // Result sink: random stalls, mostly short, a few long.
    initial
    begin : sink_pacing
        int r;
        int run;
        forever
        begin
            @(posedge clk);
            r = $urandom_range(0, 99);
            if (rx_steady)
            begin
                m_tready <= 1'b1;
                run = 1;
            end
            else if (r < 60)
            begin
                m_tready <= 1'b1;
                run = $urandom_range(1, 8);
            end
            else
            begin
                m_tready <= 1'b0;
                if (r < 90)
                    run = $urandom_range(1, 3);
                else if (r < 98)
                    run = $urandom_range(4, 15);
                else
                    run = $urandom_range(30, 60);
            end
            repeat (run - 1) @(posedge clk);
        end
    end

    // Compares each accepted result with the oldest prediction.
    always @(posedge clk)
    begin : result_check
        verdict_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            if (verdict_q.size() == 0)
                report_error($sformatf("result 0x%02h with no request pending", m_tdata));
            else
            begin
                want = verdict_q.pop_front();
                if (m_tdata[1:0] != want.status)
                    report_error($sformatf("status %0d, predicted %0d",
                                           m_tdata[1:0], want.status));
                if (m_tdata[6:2] != want.live_count)
                    report_error($sformatf("live_count %0d, predicted %0d",
                                           m_tdata[6:2], want.live_count));
                if (m_tdata[7] !== 1'b0)
                    report_error("pad bit of result is not zero");
            end
        end
    end

    initial
    begin
        for (int s = 0; s < SLOT_COUNT; s++)
        begin
            shadow_tag[s]    = '0;
            shadow_expiry[s] = '0;
            shadow_used[s]   = 1'b0;
        end
        shadow_lifetime = DEF_LIFETIME;
        shadow_skew     = DEF_SKEW;

        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_clock_and_expiry();
        test_register_extremes();
        test_table_full();
        test_random_phases();

        // Drain, then leave room for any stray result to show up.
        settle();
        repeat (40) @(posedge clk);
        if (error_count == 0)
            $display("** expiring_tag_replay_cache: PASSED **");
        else
            $display("** expiring_tag_replay_cache: FAILED **");
        $finish;
    end

endmodule

FILE: expiring_tag_replay_cache.f
hdl/etrc_pkg.sv
hdl/etrc_cell.sv
hdl/etrc_probe.sv
hdl/expiring_tag_replay_cache.sv
bench/expiring_tag_replay_cache_tb.sv
